// ----- rtl/ms_pkg.sv -----
// Package for the merge sorter: beat structs of both channels and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package ms_pkg;

  localparam int unsigned DATA_W = 32;

  // Input beat: one element of the set
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_beat_t;

  // Output beat: one element in sorted order
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     dropped;
  } out_beat_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // take input beats into buffer 0
    logic pass_init; // start a merge pass (or the emit phase)
    logic run_init;  // set up the next pair of runs
    logic merge;     // move one element into the destination buffer
    logic emit;      // stream the sorted buffer out
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last_acc;   // input beat with last flag accepted
    logic sorted;     // run width covers the whole set
    logic pass_end;   // no runs left in this pass
    logic run_last;   // this merge step fills the last slot of the run
    logic final_load; // last sorted element went into the output register
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ms_ram.sv -----
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module ms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port and registered reads (read returns old data on a collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- rtl/ms_ctrl.sv -----
// Merge sorter controller: sequences load, merge passes and emit.
// Depends on ms_pkg (cmd_t, sts_t).
`default_nettype none

module ms_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ms_pkg::sts_t sts_i,
  output ms_pkg::cmd_t      cmd_o
);

  import ms_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PASS  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (sts_i.last_acc) state_d = ST_PASS;
      ST_PASS:  state_d = sts_i.sorted ? ST_EMIT : ST_RUN;
      ST_RUN:   state_d = sts_i.pass_end ? ST_PASS : ST_MERGE;
      ST_MERGE: if (sts_i.run_last) state_d = ST_RUN;
      ST_EMIT:  if (sts_i.final_load) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD:  cmd_o.load      = 1'b1;
      ST_PASS:  cmd_o.pass_init = 1'b1;
      ST_RUN:   cmd_o.run_init  = 1'b1;
      ST_MERGE: cmd_o.merge     = 1'b1;
      ST_EMIT:  cmd_o.emit      = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ms_dp.sv -----
// Merge sorter datapath: two ping-pong element buffers, run pointers,
// the merge compare and the output register.
// Depends on ms_pkg and ms_ram.
`default_nettype none

module ms_dp #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ms_pkg::cmd_t      cmd_i,
  output ms_pkg::sts_t           sts_o,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ms_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ms_pkg::out_beat_t      out_data_o
);

  import ms_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ELEMENTS);

  // Control registers
  logic [CW-1:0] n_q, n_d;
  logic          ovf_q, ovf_d;
  logic          sel_q, sel_d;       // buffer holding the current runs
  logic [CW:0]   w_q, w_d;           // run width
  logic          out_vld_q, out_vld_d;

  // Payload registers
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] a_q, a_d;
  logic [CW-1:0] b_q, b_d;
  logic [CW-1:0] k_q, k_d;
  out_beat_t     out_q, out_d;

  // RAM ports
  logic              we0, we1;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic [DATA_W-1:0] da, db;

  logic              in_acc;
  logic              out_take;
  logic              take_a;
  logic [DATA_W-1:0] merged;
  logic [CW+1:0]     sum_mid, sum_hi;
  logic [CW-1:0]     mid_new, hi_new;
  logic [CW-1:0]     n_m1;

  assign in_stall_o = !cmd_i.load;
  assign in_acc     = in_valid_i && cmd_i.load;
  assign out_take   = !out_vld_q || !out_stall_i;
  assign n_m1       = n_q - CW'(1);

  // Source data of the current pass
  assign da = sel_q ? rd1_a : rd0_a;
  assign db = sel_q ? rd1_b : rd0_b;

  // Stable merge choice: left run wins ties
  assign take_a = (a_q < mid_q) &&
                  ((b_q >= hi_q) || ($signed(da) <= $signed(db)));
  assign merged = take_a ? da : db;

  // Run bounds clipped to the set size
  assign sum_mid = {2'b00, lo_q} + {1'b0, w_q};
  assign sum_hi  = {2'b00, lo_q} + {w_q, 1'b0};
  assign mid_new = (sum_mid > {2'b00, n_q}) ? n_q : sum_mid[CW-1:0];
  assign hi_new  = (sum_hi > {2'b00, n_q}) ? n_q : sum_hi[CW-1:0];

  // Status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.last_acc   = in_acc && in_data_i.last;
    sts_o.sorted     = w_q >= {1'b0, n_q};
    sts_o.pass_end   = lo_q >= n_q;
    sts_o.run_last   = (k_q + CW'(1)) == hi_q;
    sts_o.final_load = cmd_i.emit && out_take && (a_q == n_m1);
  end

  // Next-state logic of counters, pointers and output register
  always_comb begin
    n_d       = n_q;
    ovf_d     = ovf_q;
    sel_d     = sel_q;
    w_d       = w_q;
    lo_d      = lo_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;

    if (in_acc) begin
      if (n_q < MaxCnt) begin
        n_d = n_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.pass_init) begin
      lo_d = '0;
      a_d  = '0;
    end

    if (cmd_i.run_init) begin
      if (lo_q >= n_q) begin
        w_d   = {w_q[CW-1:0], 1'b0};
        sel_d = !sel_q;
      end else begin
        mid_d = mid_new;
        hi_d  = hi_new;
        a_d   = lo_q;
        b_d   = mid_new;
        k_d   = lo_q;
      end
    end

    if (cmd_i.merge) begin
      k_d = k_q + CW'(1);
      if (take_a) begin
        a_d = a_q + CW'(1);
      end else begin
        b_d = b_q + CW'(1);
      end
      if ((k_q + CW'(1)) == hi_q) begin
        lo_d = hi_q;
      end
    end

    if (cmd_i.emit && out_take) begin
      out_d.sorted_value = da;
      out_d.final_res    = (a_q == n_m1);
      out_d.dropped      = ovf_q;
      out_vld_d          = 1'b1;
      a_d                = a_q + CW'(1);
      if (a_q == n_m1) begin
        // set done: ready for the next one
        n_d   = '0;
        ovf_d = 1'b0;
        sel_d = 1'b0;
        w_d   = (CW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      ovf_q     <= 1'b0;
      sel_q     <= 1'b0;
      w_q       <= (CW+1)'(1);
      out_vld_q <= 1'b0;
    end else begin
      n_q       <= n_d;
      ovf_q     <= ovf_d;
      sel_q     <= sel_d;
      w_q       <= w_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Buffer writes: loads go to buffer 0, merges to the other buffer
  assign we0   = (in_acc && (n_q < MaxCnt)) || (cmd_i.merge && sel_q);
  assign we1   = cmd_i.merge && !sel_q;
  assign waddr = cmd_i.load ? n_q[AW-1:0] : k_q[AW-1:0];
  assign wdata = cmd_i.load ? in_data_i.value : merged;

  // Reads are issued with next pointers so data lines up with a_q, b_q
  ms_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_buf0 (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(a_d[AW-1:0]),
    .raddr_b_i(b_d[AW-1:0]),
    .rdata_a_o(rd0_a),
    .rdata_b_o(rd0_b)
  );

  ms_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_buf1 (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(a_d[AW-1:0]),
    .raddr_b_i(b_d[AW-1:0]),
    .rdata_a_o(rd1_a),
    .rdata_b_o(rd1_b)
  );

endmodule

`default_nettype wire

// ----- rtl/merge_sorter.sv -----
// Merge sorter top level: controller plus datapath.
// Depends on ms_pkg, ms_ctrl, ms_dp (and ms_ram below it).
//
// Collects up to MAX_ELEMENTS signed 32-bit values, one per input beat; the
// beat with last set closes the set (values past capacity are discarded and
// every result of that set has dropped set). The set is then sorted in
// ascending order by a stable bottom-up merge sort (equal keys keep input
// order) and streamed out, one beat per value, final_res on the last one.
// In the load state a beat is taken whenever one is valid. Sorting ping-pongs
// between two buffer RAMs; the single merge unit moves one element per
// cycle. Results then leave at up to one per cycle while out_stall_i is
// low. No input is taken between the last beat of a set and the load of
// its final result into the output register.
`default_nettype none

module merge_sorter #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ms_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ms_pkg::out_beat_t      out_data_o
);

  import ms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ms_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ms_dp #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
